// File: design/obf_pkg.sv
`default_nettype none
package obf_pkg;

  localparam int OW         = 16;
  localparam int QW         = 15;
  localparam int SW         = 32;
  localparam int DW         = 64;
  localparam int GW         = 82;
  localparam int RW         = 100;
  localparam int NLANE      = 9;
  localparam int NCELL      = 15;
  localparam int FRAC_SHIFT = 30;
  localparam int ONE_Q14    = 16384;
  localparam int MAX_MAG    = 32768;

  localparam int LN_UX = 0;
  localparam int LN_UY = 1;
  localparam int LN_UZ = 2;
  localparam int LN_VX = 3;
  localparam int LN_VY = 4;
  localparam int LN_VZ = 5;
  localparam int LN_WX = 6;
  localparam int LN_WY = 7;
  localparam int LN_WZ = 8;

  typedef struct packed {
    logic signed [RW-1:0] rem;
    logic [GW-1:0]        acc;
    logic [DW-1:0]        den;
    logic [QW-1:0]        q;
  } root_t;

  typedef struct packed {
    logic [NLANE-1:0] neg;
    logic             degen;
  } side_t;

endpackage
`default_nettype wire

// File: design/obf_if.sv
`default_nettype none
interface obf_normal_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] normal_x;
  logic signed [W-1:0] normal_y;
  logic signed [W-1:0] normal_z;
  modport source(output valid, output normal_x, output normal_y, output normal_z,
                 input ready);
  modport sink(input valid, input normal_x, input normal_y, input normal_z,
               output ready);
endinterface

interface obf_basis_if import obf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] u_x;
  logic signed [OW-1:0] u_y;
  logic signed [OW-1:0] u_z;
  logic signed [OW-1:0] v_x;
  logic signed [OW-1:0] v_y;
  logic signed [OW-1:0] v_z;
  logic signed [OW-1:0] w_x;
  logic signed [OW-1:0] w_y;
  logic signed [OW-1:0] w_z;
  logic                 degenerate;
  modport source(output valid, output u_x, output u_y, output u_z, output v_x,
                 output v_y, output v_z, output w_x, output w_y, output w_z,
                 output degenerate, input ready);
  modport sink(input valid, input u_x, input u_y, input u_z, input v_x,
               input v_y, input v_z, input w_x, input w_y, input w_z,
               input degenerate, output ready);
endinterface
`default_nettype wire

// File: design/obf_root_cell.sv
`default_nettype none
module obf_root_cell import obf_pkg::*; #(
  parameter int L = 0
) (
  input  logic  clk,
  input  logic  en,
  input  root_t d,
  output root_t q
);

  logic [GW-1:0] step;
  logic [GW:0]   sum;
  logic [RW-1:0] delta;
  logic          take;
  root_t         q_next;

  always_comb begin
    step   = GW'(d.den) << L;
    sum    = {d.acc, 1'b0} + (GW+1)'(step) - (GW+1)'(d.den);
    delta  = RW'(sum) << (L + 2);
    take   = d.rem >= $signed(delta);
    q_next = d;
    if (take) begin
      q_next.rem = d.rem - $signed(delta);
      q_next.acc = d.acc + step;
      q_next.q   = d.q | (QW'(1) << L);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

// File: design/obf_front.sv
`default_nettype none
module obf_front import obf_pkg::*; #(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [IN_WIDTH-1:0] nx,
  input  logic signed [IN_WIDTH-1:0] ny,
  input  logic signed [IN_WIDTH-1:0] nz,
  output logic                       out_valid,
  output root_t                      lanes [NLANE],
  output side_t                      side
);

  localparam int KW = $clog2(IN_WIDTH + 1);

  logic [4:0] vld;

  // stage 1
  logic [IN_WIDTH-1:0] mag [3];
  logic [32:0]         mext [3];
  logic [32:0]         big;
  logic [KW-1:0]       kk;
  logic                ax0_n;
  logic [2:0]          sg;
  side_t               side_n;
  logic [15:0]         x1, y1, z1;
  logic                ax0_1;
  side_t               side1;

  // stage 2
  logic [SW-1:0] xx2, yy2, zz2, c1_2, c2_2;
  logic          ax0_2;
  side_t         side2;

  // stage 3
  logic [SW-1:0] xx3, yy3, zz3, s3, p3;
  logic [DW-1:0] c1sq3, c2sq3;
  logic          ax0_3;
  side_t         side3;

  // stage 4
  logic [DW-1:0] ps;
  logic [DW-1:0] num_n [NLANE];
  logic [DW-1:0] den_n [NLANE];
  logic [DW-1:0] num4 [NLANE];
  logic [DW-1:0] den4 [NLANE];
  side_t         side4;

  always_comb begin
    sg[0] = nx[IN_WIDTH-1];
    sg[1] = ny[IN_WIDTH-1];
    sg[2] = nz[IN_WIDTH-1];
    mag[0] = sg[0] ? (~nx + 1'b1) : nx;
    mag[1] = sg[1] ? (~ny + 1'b1) : ny;
    mag[2] = sg[2] ? (~nz + 1'b1) : nz;
    for (int i = 0; i < 3; i++) begin
      mext[i] = 33'(mag[i]);
    end
    ax0_n = 1'b1;
    big   = mext[0];
    if (mext[1] > big) begin
      ax0_n = 1'b0;
      big   = mext[1];
    end
    if (mext[2] > big) begin
      ax0_n = 1'b0;
      big   = mext[2];
    end
    kk = '0;
    for (int j = IN_WIDTH; j >= 0; j--) begin
      if ((big >> j) <= 33'(MAX_MAG)) begin
        kk = KW'(j);
      end
    end
    side_n.degen      = (mext[0] == '0) && (mext[1] == '0) && (mext[2] == '0);
    side_n.neg[LN_WX] = sg[0];
    side_n.neg[LN_WY] = sg[1];
    side_n.neg[LN_WZ] = sg[2];
    if (ax0_n) begin
      side_n.neg[LN_UX] = !(sg[0] ^ sg[1]);
      side_n.neg[LN_UY] = 1'b0;
      side_n.neg[LN_UZ] = !(sg[1] ^ sg[2]);
      side_n.neg[LN_VX] = !sg[2];
      side_n.neg[LN_VY] = 1'b0;
      side_n.neg[LN_VZ] = sg[0];
    end else begin
      side_n.neg[LN_UX] = 1'b0;
      side_n.neg[LN_UY] = !(sg[0] ^ sg[1]);
      side_n.neg[LN_UZ] = !(sg[0] ^ sg[2]);
      side_n.neg[LN_VX] = 1'b0;
      side_n.neg[LN_VY] = sg[2];
      side_n.neg[LN_VZ] = !sg[1];
    end
  end

  always_comb begin
    ps = DW'(p3) * DW'(s3);
    num_n[LN_WX] = DW'(xx3);
    num_n[LN_WY] = DW'(yy3);
    num_n[LN_WZ] = DW'(zz3);
    den_n[LN_WX] = DW'(s3);
    den_n[LN_WY] = DW'(s3);
    den_n[LN_WZ] = DW'(s3);
    den_n[LN_UZ] = ps;
    num_n[LN_UZ] = c2sq3;
    den_n[LN_VX] = DW'(p3);
    den_n[LN_VY] = DW'(p3);
    den_n[LN_VZ] = DW'(p3);
    if (ax0_3) begin
      num_n[LN_UX] = c1sq3;
      den_n[LN_UX] = ps;
      num_n[LN_UY] = DW'(p3);
      den_n[LN_UY] = DW'(s3);
      num_n[LN_VX] = DW'(zz3);
      num_n[LN_VY] = '0;
      num_n[LN_VZ] = DW'(xx3);
    end else begin
      num_n[LN_UX] = DW'(p3);
      den_n[LN_UX] = DW'(s3);
      num_n[LN_UY] = c1sq3;
      den_n[LN_UY] = ps;
      num_n[LN_VX] = '0;
      num_n[LN_VY] = DW'(zz3);
      num_n[LN_VZ] = DW'(yy3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= 16'(mext[0] >> kk);
      y1    <= 16'(mext[1] >> kk);
      z1    <= 16'(mext[2] >> kk);
      ax0_1 <= ax0_n;
      side1 <= side_n;

      xx2   <= x1 * x1;
      yy2   <= y1 * y1;
      zz2   <= z1 * z1;
      c1_2  <= x1 * y1;
      c2_2  <= (ax0_1 ? y1 : x1) * z1;
      ax0_2 <= ax0_1;
      side2 <= side1;

      xx3   <= xx2;
      yy3   <= yy2;
      zz3   <= zz2;
      s3    <= xx2 + yy2 + zz2;
      p3    <= ax0_2 ? (xx2 + zz2) : (yy2 + zz2);
      c1sq3 <= DW'(c1_2) * DW'(c1_2);
      c2sq3 <= DW'(c2_2) * DW'(c2_2);
      ax0_3 <= ax0_2;
      side3 <= side2;

      num4  <= num_n;
      den4  <= den_n;
      side4 <= side3;

      for (int i = 0; i < NLANE; i++) begin
        lanes[i].rem <= $signed(RW'(num4[i]) << FRAC_SHIFT) - $signed(RW'(den4[i]));
        lanes[i].acc <= '0;
        lanes[i].den <= den4[i];
        lanes[i].q   <= '0;
      end
      side <= side4;
    end
  end

  assign out_valid = vld[4];

endmodule
`default_nettype wire

// File: design/orthonormal_basis_from_normal_top.sv
// throughput: one request per cycle; the 15-cell root chain and front pipeline
// advance together and stall only when the output register is held
// reset: synchronous, clears the valid flags only; payload registers keep data
`default_nettype none
module orthonormal_basis_from_normal_top import obf_pkg::*; #(
  parameter int IN_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  obf_normal_if.sink    normal,
  obf_basis_if.source   basis
);

  logic                 en;
  logic                 fvalid;
  side_t                fside;
  root_t                chain [NCELL+1][NLANE];
  logic [NCELL-1:0]     cvld;
  side_t                cside [NCELL];
  logic                 out_valid;
  logic signed [OW-1:0] res [NLANE];
  logic signed [OW-1:0] res_next [NLANE];
  logic                 degen;
  logic [OW-1:0]        mag;

  assign en           = !out_valid || basis.ready;
  assign normal.ready = en;

  obf_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (normal.valid),
    .nx        (normal.normal_x),
    .ny        (normal.normal_y),
    .nz        (normal.normal_z),
    .out_valid (fvalid),
    .lanes     (chain[0]),
    .side      (fside)
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    for (genvar j = 0; j < NLANE; j++) begin : g_lane
      obf_root_cell #(.L(NCELL - 1 - i)) u_cell (
        .clk (clk),
        .en  (en),
        .d   (chain[i][j]),
        .q   (chain[i+1][j])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld      <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      cvld      <= {cvld[NCELL-2:0], fvalid};
      out_valid <= cvld[NCELL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cside[0] <= fside;
      for (int i = 1; i < NCELL; i++) begin
        cside[i] <= cside[i-1];
      end
      res   <= res_next;
      degen <= cside[NCELL-1].degen;
    end
  end

  always_comb begin
    mag = '0;
    for (int j = 0; j < NLANE; j++) begin
      mag = (chain[NCELL][j].q > QW'(ONE_Q14)) ? OW'(ONE_Q14) : OW'(chain[NCELL][j].q);
      if (cside[NCELL-1].degen) begin
        res_next[j] = '0;
      end else if (cside[NCELL-1].neg[j]) begin
        res_next[j] = -$signed(mag);
      end else begin
        res_next[j] = $signed(mag);
      end
    end
  end

  assign basis.valid      = out_valid;
  assign basis.u_x        = res[LN_UX];
  assign basis.u_y        = res[LN_UY];
  assign basis.u_z        = res[LN_UZ];
  assign basis.v_x        = res[LN_VX];
  assign basis.v_y        = res[LN_VY];
  assign basis.v_z        = res[LN_VZ];
  assign basis.w_x        = res[LN_WX];
  assign basis.w_y        = res[LN_WY];
  assign basis.w_z        = res[LN_WZ];
  assign basis.degenerate = degen;

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    basis.valid && basis.degenerate |-> (basis.w_x == 0 && basis.w_y == 0 &&
      basis.w_z == 0 && basis.u_x == 0 && basis.v_y == 0))
    else $error("degenerate result with nonzero vector");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    basis.valid && !basis.ready |-> !normal.ready)
    else $error("request taken while output held");

  a_range: assert property (@(posedge clk) disable iff (rst)
    basis.valid |-> (basis.w_x <= 16'sd16384 && basis.w_x >= -16'sd16384 &&
      basis.u_y <= 16'sd16384 && basis.u_y >= -16'sd16384))
    else $error("output magnitude above one");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    basis.valid && !basis.degenerate |-> (basis.w_x != 0 || basis.w_y != 0 ||
      basis.w_z != 0))
    else $error("nonzero normal gave zero w");
`endif

endmodule
`default_nettype wire
